[design/ocr_pkg.sv]
// ocr_pkg: shared constants, register indexes and controller/datapath types
// for the occupancy report controller; no dependencies
package ocr_pkg;

    localparam int ADC_BITS_DEFAULT = 10;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_SEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VACANCY_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BATT_MV     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OCC_TX_COUNT    = 3'd6;

    // register reset values
    localparam logic [15:0] HEARTBEAT_TICKS_RST = 16'd480;
    localparam logic [15:0] VACANCY_TICKS_RST   = 16'd720;
    localparam logic [15:0] STARTUP_TICKS_RST   = 16'd90;
    localparam logic [15:0] LOW_BATT_MV_RST     = 16'd3100;
    localparam logic [1:0]  OCC_TX_COUNT_RST    = 2'd2;

    // report kinds
    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_OCCUPANCY = 2'd1;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

    // battery arithmetic
    localparam int          VREF_MV      = 1250;
    localparam int          VREF_MV_W    = 11;
    localparam logic [6:0]  DECI_DIVISOR = 7'd100;
    localparam logic [6:0]  DECI_HALF    = 7'd50;
    localparam logic [7:0]  OCC_MARK     = 8'd65;
    localparam logic [15:0] VDD_SAT      = 16'hFFFF;
    // divide by 100 as multiply by ceil(2^23/100), exact for every mv_round value (at most 65585)
    localparam int          DECI_SHIFT   = 23;
    localparam logic [16:0] DECI_RECIP   = 17'd83887;

    // frame layout
    localparam int FRAME_LEN   = 10;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);

    typedef struct packed {
        logic                   tick;
        logic                   vdd_start;
        logic                   vdd_take;
        logic                   mul;
        logic                   dv_take;
        logic                   bb_clear;
        logic                   status_only;
        logic [FRAME_IDX_W-1:0] byte_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic send;
        logic low;
        logic div_done;
    } dp_status_t;

endpackage

[design/ocr_div.sv]
// ocr_div: restoring divider, one quotient bit per cycle
// depends on nothing; used by ocr_datapath
module ocr_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    // a zero divisor always fits, so the quotient saturates to all ones
    assign rem_shift = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[design/ocr_datapath.sv]
// ocr_datapath: configuration registers, tick state, battery arithmetic, frame mux
// depends on ocr_pkg and ocr_div
module ocr_datapath #(
    parameter int ADC_BITS = ocr_pkg::ADC_BITS_DEFAULT,
    parameter int IN_W     = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ocr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic [IN_W-1:0]                   s_tdata,
    input  ocr_pkg::ctrl_cmd_t                cmd,
    output ocr_pkg::dp_status_t               sts,
    output logic [7:0]                        m_tdata,
    output logic [3:0]                        m_tuser
);

    localparam int DIV_W  = ocr_pkg::VREF_MV_W + ADC_BITS;
    localparam int PROD_W = 16 + ADC_BITS;
    localparam logic [DIV_W-1:0] VDD_NUMER = DIV_W'(ocr_pkg::VREF_MV) << ADC_BITS;

    // configuration
    logic [31:0] node_id_reg;
    logic [23:0] counter_seed_reg;
    logic [15:0] heartbeat_ticks_reg;
    logic [15:0] vacancy_ticks_reg;
    logic [15:0] startup_ticks_reg;
    logic [15:0] low_batt_mv_reg;
    logic [1:0]  occ_tx_count_reg;

    // tick state
    logic        started_reg;
    logic [15:0] hb_count_reg,  hb_count_next;
    logic [15:0] vac_count_reg, vac_count_next;
    logic [15:0] su_count_reg,  su_count_next;
    logic        motion_seen_reg, motion_seen_next;
    logic [1:0]  motion_hold_reg, motion_hold_next;
    logic [23:0] pkt_count_reg, pkt_count_next;
    logic [1:0]  kind_reg, kind_next;
    logic        send_reg, send_next;
    logic        pd_reg, pd_next;
    logic        frame_seen_reg, frame_seen_next;

    // battery path
    logic [ADC_BITS-1:0] ref_reg;
    logic [ADC_BITS-1:0] batt_reg;
    logic [15:0]         vdd_reg;
    logic [15:0]         mv_reg;
    logic [7:0]          bb_reg;
    logic [PROD_W-1:0]   prod;
    logic [16:0]         mv_round;
    logic [33:0]         dv_prod;

    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    logic btn, mot, radio;
    assign btn   = s_tdata[0];
    assign mot   = s_tdata[1];
    assign radio = s_tdata[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg         <= '0;
            counter_seed_reg    <= '0;
            heartbeat_ticks_reg <= ocr_pkg::HEARTBEAT_TICKS_RST;
            vacancy_ticks_reg   <= ocr_pkg::VACANCY_TICKS_RST;
            startup_ticks_reg   <= ocr_pkg::STARTUP_TICKS_RST;
            low_batt_mv_reg     <= ocr_pkg::LOW_BATT_MV_RST;
            occ_tx_count_reg    <= ocr_pkg::OCC_TX_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ocr_pkg::REG_NODE_ID:         node_id_reg         <= cfg_data;
                ocr_pkg::REG_COUNTER_SEED:    counter_seed_reg    <= cfg_data[23:0];
                ocr_pkg::REG_HEARTBEAT_TICKS: heartbeat_ticks_reg <= cfg_data[15:0];
                ocr_pkg::REG_VACANCY_TICKS:   vacancy_ticks_reg   <= cfg_data[15:0];
                ocr_pkg::REG_STARTUP_TICKS:   startup_ticks_reg   <= cfg_data[15:0];
                ocr_pkg::REG_LOW_BATT_MV:     low_batt_mv_reg     <= cfg_data[15:0];
                ocr_pkg::REG_OCC_TX_COUNT:    occ_tx_count_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // per-tick decision
    always_comb begin
        logic [15:0] hb0, vac0, su0, vac1;
        logic [23:0] pc0;
        logic        ms0, ms1;
        logic [1:0]  mh0, mh1;
        logic        hold;
        if (!started_reg) begin
            hb0 = heartbeat_ticks_reg;
            vac0 = vacancy_ticks_reg;
            pc0 = counter_seed_reg;
            su0 = '0;
            ms0 = 1'b0;
            mh0 = '0;
        end else begin
            hb0 = hb_count_reg;
            vac0 = vac_count_reg;
            pc0 = pkt_count_reg;
            su0 = su_count_reg;
            ms0 = motion_seen_reg;
            mh0 = motion_hold_reg;
        end

        hb_count_next = btn ? hb0 : hb0 + 16'd1;
        su_count_next = (su0 < startup_ticks_reg) ? su0 + 16'd1 : su0;
        mh1  = mot ? 2'd2 : mh0;
        hold = mh1 != 2'd0;
        ms1  = ms0 | hold;

        vac1 = vac0;
        if (hold && (su_count_next >= startup_ticks_reg)) begin
            if (vac0 == vacancy_ticks_reg) begin
                vac1 = '0;
            end else if (vac0 > 16'd2) begin
                vac1 = 16'd2;
            end
        end

        if (vac1 < {14'd0, occ_tx_count_reg}) begin
            kind_next = ocr_pkg::KIND_OCCUPANCY;
        end else if (hb_count_next >= heartbeat_ticks_reg) begin
            kind_next = ocr_pkg::KIND_HEARTBEAT;
        end else begin
            kind_next = ocr_pkg::KIND_NONE;
        end

        frame_seen_next  = ms1;
        motion_seen_next = ms1;
        pkt_count_next   = pc0;
        send_next        = 1'b0;
        if (kind_next != ocr_pkg::KIND_NONE) begin
            send_next        = radio;
            pkt_count_next   = radio ? pc0 + 24'd1 : pc0;
            motion_seen_next = 1'b0;
            hb_count_next    = '0;
        end

        vac_count_next   = (vac1 < vacancy_ticks_reg) ? vac1 + 16'd1 : vac1;
        pd_next          = hold;
        motion_hold_next = hold ? mh1 - 2'd1 : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg     <= 1'b0;
            hb_count_reg    <= '0;
            vac_count_reg   <= '0;
            su_count_reg    <= '0;
            motion_seen_reg <= 1'b0;
            motion_hold_reg <= '0;
            pkt_count_reg   <= '0;
            kind_reg        <= ocr_pkg::KIND_NONE;
            send_reg        <= 1'b0;
            pd_reg          <= 1'b0;
        end else if (cmd.tick) begin
            started_reg     <= 1'b1;
            hb_count_reg    <= hb_count_next;
            vac_count_reg   <= vac_count_next;
            su_count_reg    <= su_count_next;
            motion_seen_reg <= motion_seen_next;
            motion_hold_reg <= motion_hold_next;
            pkt_count_reg   <= pkt_count_next;
            kind_reg        <= kind_next;
            send_reg        <= send_next;
            pd_reg          <= pd_next;
        end
    end

    // battery measurement
    assign prod     = {{ADC_BITS{1'b0}}, vdd_reg} * {16'd0, batt_reg};
    assign mv_round = {1'b0, mv_reg} + {10'd0, ocr_pkg::DECI_HALF};
    // rounded decivolts by reciprocal multiply
    assign dv_prod  = {17'd0, mv_round} * {17'd0, ocr_pkg::DECI_RECIP};

    ocr_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (ADC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.vdd_start),
        .dividend (VDD_NUMER),
        .divisor  (ref_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            frame_seen_reg <= frame_seen_next;
            ref_reg        <= s_tdata[3 +: ADC_BITS];
            batt_reg       <= s_tdata[3 + ADC_BITS +: ADC_BITS];
        end
        if (cmd.vdd_take) begin
            vdd_reg <= (|div_q[DIV_W-1:16]) ? ocr_pkg::VDD_SAT : div_q[15:0];
        end
        if (cmd.mul) begin
            // halve-scale product, then doubled modulo 2^16
            mv_reg <= {prod[ADC_BITS +: 15], 1'b0};
        end
        if (cmd.bb_clear) begin
            bb_reg <= '0;
        end else if (cmd.dv_take) begin
            bb_reg <= dv_prod[ocr_pkg::DECI_SHIFT +: 8];
        end
    end

    assign sts.send     = send_reg;
    assign sts.low      = mv_reg < low_batt_mv_reg;
    assign sts.div_done = div_done;

    always_comb begin
        case (cmd.byte_idx)
            4'd0:    m_tdata = node_id_reg[31:24];
            4'd1:    m_tdata = node_id_reg[23:16];
            4'd2:    m_tdata = node_id_reg[15:8];
            4'd3:    m_tdata = node_id_reg[7:0];
            4'd4:    m_tdata = pkt_count_reg[23:16];
            4'd5:    m_tdata = pkt_count_reg[15:8];
            4'd6:    m_tdata = pkt_count_reg[7:0];
            4'd7:    m_tdata = bb_reg;
            4'd9:    m_tdata = (kind_reg == ocr_pkg::KIND_OCCUPANCY) ? ocr_pkg::OCC_MARK
                                                                     : {7'd0, frame_seen_reg};
            default: m_tdata = 8'd0;
        endcase
        if (cmd.status_only) begin
            m_tdata = 8'd0;
        end
    end

    // tuser: byte_valid, tx_kind[1:0], pull_down
    assign m_tuser = {pd_reg, kind_reg, ~cmd.status_only};

endmodule

[design/ocr_ctrl.sv]
// ocr_ctrl: sequencer for one wake tick, from acceptance to the last word out
// depends on ocr_pkg
module ocr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    input  ocr_pkg::dp_status_t sts,
    output ocr_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_VDD_DIV,
        ST_MULT,
        ST_ROUND,
        ST_EMIT
    } state_t;

    localparam int IDX_W = ocr_pkg::FRAME_IDX_W;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             so_reg, so_next;
    logic             last;

    assign last = so_reg || (idx_reg == IDX_W'(ocr_pkg::FRAME_LEN - 1));

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        so_next         = so_reg;
        cmd             = '0;
        cmd.status_only = so_reg;
        cmd.byte_idx    = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.tick   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                idx_next = '0;
                if (sts.send) begin
                    so_next       = 1'b0;
                    cmd.vdd_start = 1'b1;
                    state_next    = ST_VDD_DIV;
                end else begin
                    so_next    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_VDD_DIV: begin
                if (sts.div_done) begin
                    cmd.vdd_take = 1'b1;
                    state_next   = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mul    = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (sts.low) begin
                    cmd.bb_clear = 1'b1;
                end else begin
                    cmd.dv_take = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            so_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            so_reg    <= so_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_EMIT;
    assign m_tlast  = last;

endmodule

[design/occupancy_report_controller.sv]
// occupancy_report_controller: top level joining sequencer and datapath
// depends on ocr_pkg, ocr_ctrl, ocr_datapath (and ocr_div below it)
//
// usage
// - one input word per wake tick on s_*: event flags and two adc samples
// - each tick gives either a ten-word frame or a single status-only word
//   on m_*; tuser carries byte_valid, tx_kind and pull_down, tlast marks the
//   final word of the tick
// - registers are written on cfg_* while no tick is in flight; cfg_ready is
//   always high, indexes beyond the register list are dropped
// - one tick is handled at a time: s_tready is high only when the previous
//   tick's last word has been taken
// - sequence: a status-only word is offered once the CHECK state after acceptance
//   has passed; a frame's first word follows CHECK, the bit-serial supply
//   voltage divide in VDD_DIV, and the MULT and ROUND states
// - then one frame word per cycle while the receiver is ready, and a return to
//   IDLE before the next tick can be accepted
// - a stalled receiver simply holds the current word; nothing else advances
// - synchronous active-low reset restores register defaults and the
//   not-started state; counters reload from config on the first tick
module occupancy_report_controller #(
    parameter int ADC_BITS = ocr_pkg::ADC_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ocr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    // tick input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: button_press, motion_event, radio_ready, ref_sample, batt_sample
    input  logic [((3+2*ADC_BITS+7)/8)*8-1:0] s_tdata,
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: frame_byte
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast,
    // tuser: byte_valid, tx_kind[1:0], pull_down
    output logic [3:0]                    m_tuser
);

    localparam int IN_W = ((3 + 2*ADC_BITS + 7) / 8) * 8;

    ocr_pkg::ctrl_cmd_t  cmd;
    ocr_pkg::dp_status_t sts;

    // the user must write config only while idle, not enforced here; cfg_ready is high
    assign cfg_ready = 1'b1;

    ocr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    ocr_datapath #(
        .ADC_BITS (ADC_BITS),
        .IN_W     (IN_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // never take a new tick while a word of the current one is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result word pending");

    // a status-only word is always the only word of its tick
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("status-only word without tlast");

    // an accepted tick closes the input until its results are out
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after accepting a tick");

    // the last word handed over reopens the input
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("input not reopened after last word");

endmodule
